// ----- sv/clrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and reset constants for the call launch retry controller.
package clrc_pkg;

  // Default widths handed to the top-level parameters.
  localparam int TIME_W_DEF = 32;
  localparam int FAIL_W_DEF = 16;

  // Fixed widths of the channel and configuration fields.
  localparam int NOW_W       = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int MAXREF_W    = 8;
  localparam int FAIL_OUT_W  = 16;

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH = 2;

  // Input mode codes.
  localparam logic [1:0] MODE_POLL  = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;
  localparam logic [1:0] MODE_RETRY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REFRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_IVL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_RETRY = 3'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0]    ACC_TIMEOUT_RST = 32'd30000;
  localparam logic [MAXREF_W-1:0] MAX_REFRESH_RST = 8'd3;
  localparam logic [CFG_W-1:0]    REFRESH_IVL_RST = 32'd5000;
  localparam logic [CFG_W-1:0]    PLACE_RETRY_RST = 32'd2000;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_RETRY = 2'd2,
    OP_IDLE  = 2'd3
  } clrc_op_t;

  typedef enum logic [1:0] {
    ACT_NOTHING = 2'd0,
    ACT_FAILED  = 2'd1,
    ACT_REFRESH = 2'd2,
    ACT_PLACE   = 2'd3
  } clrc_act_t;

  typedef struct packed {
    clrc_op_t         op;
    logic [NOW_W-1:0] now_ms;
    logic             live_call;
    logic             call_wanted;
    logic             link_room;
    logic             refresh_ready;
    logic             attempt_open;
  } clrc_item_t;

  typedef struct packed {
    logic [CFG_W-1:0]    acc_timeout;
    logic [MAXREF_W-1:0] max_refreshes;
    logic [CFG_W-1:0]    refresh_ivl;
    logic [CFG_W-1:0]    place_retry;
  } clrc_cfg_t;

endpackage

// ----- sv/call_launch_retry_controller_unit.sv -----
`timescale 1ns / 1ps
// Top level of the call launch retry controller: configuration registers and wiring.
//
// Each input word is one poll (or a begin / retry-now command) with the current
// millisecond time and five status flags; each produces exactly one result word
// with the chosen action, the failure total and the awaiting and failed flags.
// Both channels use valid/stall: a word moves on a clock edge where valid is high
// and stall is low.
// Each accepted word passes through the front decode register and then the
// two-entry queue; the result register in the back part then presents it.
// Throughput is one word per cycle while the receiver does not stall; the per-word
// work is a few adds and compares on the launch state, done combinationally ahead
// of the result register.
// When the receiver stalls, the result register holds, the queue fills, and only
// then is in_stall raised, so the input side can take up to three more words (two
// in the queue, one in the front register) before it stalls.
// Synchronous reset clears all launch state, the failure count, the queue and the
// valid flags, and loads the configuration defaults. Configuration writes are taken
// on any edge with cfg_we high outside reset; writes to unknown indexes are ignored.
module call_launch_retry_controller_unit #(
  parameter int TIME_WIDTH       = clrc_pkg::TIME_W_DEF,
  parameter int FAIL_COUNT_WIDTH = clrc_pkg::FAIL_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_mode,
  input  logic [clrc_pkg::NOW_W-1:0]       in_now_ms,
  input  logic                             in_live_call,
  input  logic                             in_call_wanted,
  input  logic                             in_link_room,
  input  logic                             in_refresh_ready,
  input  logic                             in_attempt_open,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_action,
  output logic [clrc_pkg::FAIL_OUT_W-1:0]  out_failure_total,
  output logic                             out_awaiting_flag,
  output logic                             out_failed_flag,
  input  logic                             cfg_we,
  input  logic [clrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clrc_pkg::CFG_W-1:0]       cfg_wdata
);
  import clrc_pkg::*;

  clrc_cfg_t  cfg_r, cfg_nxt;
  logic       fr_valid, fr_ready;
  clrc_item_t fr_item;
  logic       q_valid, q_pop;
  clrc_item_t q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACC_TIMEOUT: cfg_nxt.acc_timeout   = cfg_wdata;
        CFG_MAX_REFRESH: cfg_nxt.max_refreshes = cfg_wdata[MAXREF_W-1:0];
        CFG_REFRESH_IVL: cfg_nxt.refresh_ivl   = cfg_wdata;
        CFG_PLACE_RETRY: cfg_nxt.place_retry   = cfg_wdata;
        default:         cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.acc_timeout   <= ACC_TIMEOUT_RST;
      cfg_r.max_refreshes <= MAX_REFRESH_RST;
      cfg_r.refresh_ivl   <= REFRESH_IVL_RST;
      cfg_r.place_retry   <= PLACE_RETRY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  clrc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_now_ms        (in_now_ms),
    .in_live_call     (in_live_call),
    .in_call_wanted   (in_call_wanted),
    .in_link_room     (in_link_room),
    .in_refresh_ready (in_refresh_ready),
    .in_attempt_open  (in_attempt_open),
    .fr_valid         (fr_valid),
    .fr_ready         (fr_ready),
    .fr_item          (fr_item)
  );

  clrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_en     (q_pop),
    .pop_item   (q_item)
  );

  clrc_back #(
    .TIME_WIDTH       (TIME_WIDTH),
    .FAIL_COUNT_WIDTH (FAIL_COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .cfg               (cfg_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_failure_total (out_failure_total),
    .out_awaiting_flag (out_awaiting_flag),
    .out_failed_flag   (out_failed_flag)
  );

endmodule

// ----- sv/clrc_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts input words, decodes the mode and registers the item.
module clrc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_mode,
  input  logic [clrc_pkg::NOW_W-1:0] in_now_ms,
  input  logic                    in_live_call,
  input  logic                    in_call_wanted,
  input  logic                    in_link_room,
  input  logic                    in_refresh_ready,
  input  logic                    in_attempt_open,
  output logic                    fr_valid,
  input  logic                    fr_ready,
  output clrc_pkg::clrc_item_t    fr_item
);
  import clrc_pkg::*;

  logic       fr_v_r, fr_v_nxt;
  clrc_item_t fr_item_r, fr_item_nxt;
  clrc_op_t   op_dec;
  logic       take;

  always_comb begin
    unique case (in_mode)
      MODE_POLL:  op_dec = OP_POLL;
      MODE_BEGIN: op_dec = OP_BEGIN;
      MODE_RETRY: op_dec = OP_RETRY;
      default:    op_dec = OP_IDLE;
    endcase
  end

  // The holding register frees up whenever its word moves into the queue.
  assign in_stall = fr_v_r && !fr_ready;
  assign take     = in_valid && !in_stall;

  always_comb begin
    fr_v_nxt    = fr_v_r;
    fr_item_nxt = fr_item_r;
    if (!in_stall) begin
      fr_v_nxt = in_valid;
    end
    if (take) begin
      fr_item_nxt.op            = op_dec;
      fr_item_nxt.now_ms        = in_now_ms;
      fr_item_nxt.live_call     = in_live_call;
      fr_item_nxt.call_wanted   = in_call_wanted;
      fr_item_nxt.link_room     = in_link_room;
      fr_item_nxt.refresh_ready = in_refresh_ready;
      fr_item_nxt.attempt_open  = in_attempt_open;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

  assign fr_valid = fr_v_r;
  assign fr_item  = fr_item_r;

endmodule

// ----- sv/clrc_queue.sv -----
`timescale 1ns / 1ps
// Short queue of decoded items between the front and back parts.
module clrc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  clrc_pkg::clrc_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_en,
  output clrc_pkg::clrc_item_t pop_item
);
  import clrc_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(Q_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(Q_DEPTH - 1);

  clrc_item_t       slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != DEPTH_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/clrc_back.sv -----
`timescale 1ns / 1ps
// Back part: launch state, deadline checks and the registered result word.
module clrc_back #(
  parameter int TIME_WIDTH       = clrc_pkg::TIME_W_DEF,
  parameter int FAIL_COUNT_WIDTH = clrc_pkg::FAIL_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  clrc_pkg::clrc_item_t     q_item,
  input  clrc_pkg::clrc_cfg_t      cfg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_action,
  output logic [clrc_pkg::FAIL_OUT_W-1:0] out_failure_total,
  output logic                     out_awaiting_flag,
  output logic                     out_failed_flag
);
  import clrc_pkg::*;

  localparam logic [FAIL_COUNT_WIDTH-1:0] FAIL_MAX = '1;

  logic [TIME_WIDTH-1:0]       npt_r, npt_nxt;
  logic [TIME_WIDTH-1:0]       fpt_r, fpt_nxt;
  logic [TIME_WIDTH-1:0]       nrt_r, nrt_nxt;
  logic                        await_r, await_nxt;
  logic                        failed_r, failed_nxt;
  logic [MAXREF_W-1:0]         rcnt_r, rcnt_nxt;
  logic [FAIL_COUNT_WIDTH-1:0] fcnt_r, fcnt_nxt;

  logic                        ov_r, ov_nxt;
  clrc_act_t                   act_r, act_nxt;
  logic [FAIL_OUT_W-1:0]       ftot_r;
  logic                        oaw_r, ofl_r;

  logic [TIME_WIDTH-1:0] now_t, acc_t, rivl_t, pretry_t;
  logic [TIME_WIDTH-1:0] refresh_due, place_due, npt_eff;
  logic                  timed_out, refresh_ok;

  assign now_t    = TIME_WIDTH'(q_item.now_ms);
  assign acc_t    = TIME_WIDTH'(cfg.acc_timeout);
  assign rivl_t   = TIME_WIDTH'(cfg.refresh_ivl);
  assign pretry_t = TIME_WIDTH'(cfg.place_retry);

  // Sums wrap at the time width; all compares are plain unsigned.
  assign refresh_due = now_t + rivl_t;
  assign place_due   = now_t + pretry_t;
  assign timed_out   = await_r && (now_t >= fpt_r) && ((now_t - fpt_r) >= acc_t);
  assign refresh_ok  = await_r && (rcnt_r < cfg.max_refreshes) &&
                       q_item.refresh_ready && (now_t >= nrt_r);
  // A placement deadline more than one retry spacing ahead is stale.
  assign npt_eff     = (npt_r > place_due) ? '0 : npt_r;

  // A word leaves the queue whenever the result register is free or draining.
  assign q_pop = q_valid && (!ov_r || !out_stall);

  always_comb begin
    npt_nxt    = npt_r;
    fpt_nxt    = fpt_r;
    nrt_nxt    = nrt_r;
    await_nxt  = await_r;
    failed_nxt = failed_r;
    rcnt_nxt   = rcnt_r;
    fcnt_nxt   = fcnt_r;
    act_nxt    = ACT_NOTHING;
    unique case (q_item.op)
      OP_POLL: begin
        priority if (q_item.live_call) begin
          await_nxt  = 1'b0;
          failed_nxt = 1'b0;
          nrt_nxt    = '0;
          rcnt_nxt   = '0;
        end else if (!q_item.call_wanted) begin
          await_nxt = 1'b0;
        end else if (timed_out) begin
          if (!failed_r) begin
            failed_nxt = 1'b1;
            if (fcnt_r != FAIL_MAX) begin
              fcnt_nxt = fcnt_r + 1'b1;
            end
            act_nxt = ACT_FAILED;
          end
        end else if (failed_r || !q_item.link_room) begin
          act_nxt = ACT_NOTHING;
        end else if (refresh_ok) begin
          rcnt_nxt = rcnt_r + 1'b1;
          nrt_nxt  = refresh_due;
          act_nxt  = ACT_REFRESH;
        end else if (q_item.attempt_open) begin
          act_nxt = ACT_NOTHING;
        end else begin
          npt_nxt = npt_eff;
          if (now_t >= npt_eff) begin
            if (!await_r) begin
              await_nxt = 1'b1;
              fpt_nxt   = now_t;
              nrt_nxt   = refresh_due;
              rcnt_nxt  = '0;
            end
            npt_nxt = place_due;
            act_nxt = ACT_PLACE;
          end
        end
      end
      OP_BEGIN: begin
        npt_nxt    = '0;
        fpt_nxt    = '0;
        await_nxt  = 1'b0;
        failed_nxt = 1'b0;
        nrt_nxt    = '0;
        rcnt_nxt   = '0;
      end
      OP_RETRY: begin
        npt_nxt = '0;
      end
      default: begin
        act_nxt = ACT_NOTHING;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (q_pop) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npt_r    <= '0;
      fpt_r    <= '0;
      nrt_r    <= '0;
      await_r  <= 1'b0;
      failed_r <= 1'b0;
      rcnt_r   <= '0;
      fcnt_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (q_pop) begin
        npt_r    <= npt_nxt;
        fpt_r    <= fpt_nxt;
        nrt_r    <= nrt_nxt;
        await_r  <= await_nxt;
        failed_r <= failed_nxt;
        rcnt_r   <= rcnt_nxt;
        fcnt_r   <= fcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      act_r  <= act_nxt;
      ftot_r <= FAIL_OUT_W'(fcnt_nxt);
      oaw_r  <= await_nxt;
      ofl_r  <= failed_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_action        = act_r;
  assign out_failure_total = ftot_r;
  assign out_awaiting_flag = oaw_r;
  assign out_failed_flag   = ofl_r;

endmodule

// ----- sv/clrc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the call launch retry controller, bound to the top level.
module clrc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_action,
  input logic [clrc_pkg::FAIL_OUT_W-1:0] out_failure_total,
  input logic                            out_awaiting_flag,
  input logic                            out_failed_flag
);
  import clrc_pkg::*;

  // A stalled result word must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_failure_total) && $stable(out_awaiting_flag) && $stable(out_failed_flag))
    else $error("result word changed while stalled");

  // A failure report always leaves the launch marked as failed.
  a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_FAILED) |-> out_failed_flag)
    else $error("failure reported without failed flag");

  // Placing a call starts or continues an unfailed launch.
  a_place_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_PLACE) |-> out_awaiting_flag && !out_failed_flag)
    else $error("placement with wrong launch flags");

  // Refreshes are only requested for a launch still waiting for acceptance.
  a_refresh_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_REFRESH) |-> out_awaiting_flag && !out_failed_flag)
    else $error("refresh with wrong launch flags");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind call_launch_retry_controller_unit clrc_checker u_clrc_checker (.*);
